@@ rtl/core/cma_pkg.sv @@
// Shared constants for the centered moving average smoother.
`timescale 1ns / 1ps
`default_nettype none

package cma_pkg;

    // Window length register
    localparam int unsigned WL_W     = 5;
    localparam logic [WL_W-1:0] WL_RESET = 5'd5;

    // Fraction bits of the mean
    localparam int unsigned FRAC_W = 8;

    // Back-end sequencer state codes
    localparam int unsigned ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
    localparam logic [ST_W-1:0] ST_EVAL = 3'd1;
    localparam logic [ST_W-1:0] ST_READ = 3'd2;
    localparam logic [ST_W-1:0] ST_ACC  = 3'd3;
    localparam logic [ST_W-1:0] ST_DIV  = 3'd4;
    localparam logic [ST_W-1:0] ST_DONE = 3'd5;

endpackage

`default_nettype wire

@@ rtl/core/cma_front.sv @@
// Input side: accepts samples, tracks the series index and ring slot, flags the last item.
`timescale 1ns / 1ps
`default_nettype none

module cma_front #(
    parameter int unsigned MAX_WINDOW      = 31,
    parameter int unsigned SAMPLE_BITS     = 16,
    parameter int unsigned MAX_SERIES_LOG2 = 16,
    localparam int unsigned PTR_W = $clog2(MAX_WINDOW),
    localparam int unsigned ENT_W = 1 + PTR_W + MAX_SERIES_LOG2 + SAMPLE_BITS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    input  wire logic                   final_sample,
    output logic                        push,
    output logic [ENT_W-1:0]            push_data,
    input  wire logic                   q_full
);

    logic [MAX_SERIES_LOG2-1:0] seen_reg, seen_next;
    logic [PTR_W-1:0]           ptr_reg, ptr_next;
    logic                       last;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;
    // an overlong series is cut at the top index
    assign last     = final_sample || (seen_reg == {MAX_SERIES_LOG2{1'b1}});
    assign push_data = {last, ptr_reg, seen_reg, sample};

    always_comb
    begin
        seen_next = seen_reg;
        ptr_next  = ptr_reg;
        if (push)
        begin
            if (last)
            begin
                seen_next = '0;
                ptr_next  = '0;
            end
            else
            begin
                seen_next = seen_reg + 1'b1;
                if (ptr_reg == PTR_W'(MAX_WINDOW - 1))
                    ptr_next = '0;
                else
                    ptr_next = ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            ptr_reg  <= '0;
        end
        else
        begin
            seen_reg <= seen_next;
            ptr_reg  <= ptr_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/cma_queue.sv @@
// Two-entry queue between the input side and the compute side.
`timescale 1ns / 1ps
`default_nettype none

module cma_queue #(
    parameter int unsigned WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic [WIDTH-1:0]      pop_data
);

    logic [WIDTH-1:0] data_reg [2];
    logic             wr_reg, wr_next;
    logic             rd_reg, rd_next;
    logic [1:0]       cnt_reg, cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_data  = data_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? !wr_reg : wr_reg;
        rd_next  = pop ? !rd_reg : rd_reg;
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            data_reg[wr_reg] <= push_data;
    end

endmodule

`default_nettype wire

@@ rtl/core/cma_back.sv @@
// Compute side: sample ring, span accumulation, divide by span length, result register.
`timescale 1ns / 1ps
`default_nettype none

module cma_back #(
    parameter int unsigned MAX_WINDOW      = 31,
    parameter int unsigned SAMPLE_BITS     = 16,
    parameter int unsigned MAX_SERIES_LOG2 = 16,
    localparam int unsigned PTR_W  = $clog2(MAX_WINDOW),
    localparam int unsigned ENT_W  = 1 + PTR_W + MAX_SERIES_LOG2 + SAMPLE_BITS,
    localparam int unsigned MEAN_W = SAMPLE_BITS + cma_pkg::FRAC_W
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [cma_pkg::WL_W-1:0]   window_length,
    input  wire logic                       q_not_empty,
    input  wire logic [ENT_W-1:0]           q_data,
    output logic                            q_pop,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [MEAN_W-1:0]               mean_value,
    output logic [MAX_SERIES_LOG2-1:0]      position,
    output logic                            run_end
);

    localparam int unsigned SL    = MAX_SERIES_LOG2;
    localparam int unsigned CAP   = (MAX_WINDOW - 1) / 2;
    localparam int unsigned HW_W  = $clog2(CAP + 1);
    localparam int unsigned ZW    = $clog2(MAX_WINDOW + 1);
    localparam int unsigned SUM_W = SAMPLE_BITS + ZW;
    localparam int unsigned NUM_W = SUM_W + cma_pkg::FRAC_W;
    localparam int unsigned DC_W  = $clog2(NUM_W + 1);

    // queue entry fields
    logic                   e_last;
    logic [PTR_W-1:0]       e_ptr;
    logic [SL-1:0]          e_idx;
    logic [SAMPLE_BITS-1:0] e_sample;
    assign {e_last, e_ptr, e_idx, e_sample} = q_data;

    // half window from the register
    logic [cma_pkg::WL_W-1:0] w_odd;
    logic [cma_pkg::WL_W-2:0] hw_raw;
    logic [HW_W-1:0]          hw_cfg;
    always_comb
    begin
        w_odd  = window_length | cma_pkg::WL_W'(1);
        hw_raw = w_odd[cma_pkg::WL_W-1:1];
        if (32'(hw_raw) > CAP)
            hw_cfg = HW_W'(CAP);
        else
            hw_cfg = HW_W'(hw_raw);
    end

    logic [SAMPLE_BITS-1:0] mem [MAX_WINDOW];

    logic [cma_pkg::ST_W-1:0] st_reg, st_next;
    logic [SL-1:0]            nxt_reg, nxt_next;
    logic [PTR_W-1:0]         optr_reg, optr_next;
    logic                     ov_reg, ov_next;

    logic                     last_reg, last_next;
    logic [SL-1:0]            m_reg, m_next;
    logic [HW_W-1:0]          hw_reg, hw_next;
    logic [PTR_W-1:0]         rptr_reg, rptr_next;
    logic [HW_W:0]            cnt_reg, cnt_next;
    logic [ZW-1:0]            z_reg, z_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [NUM_W-1:0]         num_reg, num_next;
    logic [ZW-1:0]            rem_reg, rem_next;
    logic [DC_W-1:0]          dc_reg, dc_next;
    logic                     neg_reg, neg_next;
    logic [SAMPLE_BITS-1:0]   rd_reg;
    logic [MEAN_W-1:0]        mean_reg, mean_next;
    logic [SL-1:0]            pos_reg, pos_next;
    logic                     end_reg, end_next;

    // span evaluation
    logic            go;
    logic [SL-1:0]   dist_hi;
    logic [SL-1:0]   h_wide;
    logic [HW_W-1:0] h;
    logic [PTR_W:0]  start_w;
    logic [ZW:0]     rem_sh;
    logic [SUM_W-1:0] mag;
    logic [NUM_W-1:0] q_signed;

    always_comb
    begin
        go = (nxt_reg <= m_reg) &&
             (last_reg || ({1'b0, nxt_reg} + (SL+1)'(hw_reg) <= {1'b0, m_reg}));
        dist_hi = m_reg - nxt_reg;
        h_wide  = SL'(hw_reg);
        if (nxt_reg < h_wide)
            h_wide = nxt_reg;
        if (dist_hi < h_wide)
            h_wide = dist_hi;
        h = HW_W'(h_wide);
        if ({1'b0, optr_reg} >= (PTR_W+1)'(h))
            start_w = {1'b0, optr_reg} - (PTR_W+1)'(h);
        else
            start_w = {1'b0, optr_reg} + (PTR_W+1)'(MAX_WINDOW) - (PTR_W+1)'(h);
        rem_sh   = {rem_reg, num_reg[NUM_W-1]};
        mag      = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        q_signed = neg_reg ? -num_reg : num_reg;
    end

    always_comb
    begin
        st_next   = st_reg;
        nxt_next  = nxt_reg;
        optr_next = optr_reg;
        ov_next   = ov_reg;
        last_next = last_reg;
        m_next    = m_reg;
        hw_next   = hw_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        z_next    = z_reg;
        sum_next  = sum_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        dc_next   = dc_reg;
        neg_next  = neg_reg;
        mean_next = mean_reg;
        pos_next  = pos_reg;
        end_next  = end_reg;
        q_pop     = 1'b0;

        if (ov_reg && !out_stall)
            ov_next = 1'b0;

        unique case (st_reg)
            cma_pkg::ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop     = 1'b1;
                    last_next = e_last;
                    m_next    = e_idx;
                    hw_next   = hw_cfg;
                    st_next   = cma_pkg::ST_EVAL;
                end
            end
            cma_pkg::ST_EVAL:
            begin
                if (go)
                begin
                    rptr_next = PTR_W'(start_w);
                    cnt_next  = {h, 1'b0};
                    z_next    = ZW'({h, 1'b1});
                    sum_next  = '0;
                    st_next   = cma_pkg::ST_READ;
                end
                else
                begin
                    if (last_reg)
                    begin
                        nxt_next  = '0;
                        optr_next = '0;
                    end
                    st_next = cma_pkg::ST_IDLE;
                end
            end
            cma_pkg::ST_READ:
            begin
                st_next = cma_pkg::ST_ACC;
            end
            cma_pkg::ST_ACC:
            begin
                sum_next = sum_reg +
                    SUM_W'($signed({{(SUM_W-SAMPLE_BITS){rd_reg[SAMPLE_BITS-1]}}, rd_reg}));
                if (cnt_reg == '0)
                    st_next = cma_pkg::ST_DIV;
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                    if (rptr_reg == PTR_W'(MAX_WINDOW - 1))
                        rptr_next = '0;
                    else
                        rptr_next = rptr_reg + 1'b1;
                    st_next = cma_pkg::ST_READ;
                end
                // set up the divider on the final term
                if (cnt_reg == '0)
                begin
                    neg_next = sum_next[SUM_W-1];
                    num_next = '0;
                    rem_next = '0;
                    dc_next  = DC_W'(NUM_W);
                end
            end
            cma_pkg::ST_DIV:
            begin
                if (dc_reg == DC_W'(NUM_W))
                begin
                    // first DIV cycle loads the magnitude
                    num_next = {mag, cma_pkg::FRAC_W'(0)};
                    dc_next  = dc_reg - 1'b1;
                end
                else
                begin
                    if (rem_sh >= {1'b0, z_reg})
                    begin
                        rem_next = ZW'(rem_sh - {1'b0, z_reg});
                        num_next = {num_reg[NUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = ZW'(rem_sh);
                        num_next = {num_reg[NUM_W-2:0], 1'b0};
                    end
                    if (dc_reg == '0)
                        st_next = cma_pkg::ST_DONE;
                    else
                        dc_next = dc_reg - 1'b1;
                end
            end
            cma_pkg::ST_DONE:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next   = 1'b1;
                    mean_next = MEAN_W'(q_signed);
                    pos_next  = nxt_reg;
                    end_next  = last_reg && (nxt_reg == m_reg);
                    if (last_reg && (nxt_reg == m_reg))
                    begin
                        // series closed; the index may sit at its top value
                        nxt_next  = '0;
                        optr_next = '0;
                        st_next   = cma_pkg::ST_IDLE;
                    end
                    else
                    begin
                        nxt_next = nxt_reg + 1'b1;
                        if (optr_reg == PTR_W'(MAX_WINDOW - 1))
                            optr_next = '0;
                        else
                            optr_next = optr_reg + 1'b1;
                        st_next = cma_pkg::ST_EVAL;
                    end
                end
            end
            default:
            begin
                st_next = cma_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= cma_pkg::ST_IDLE;
            nxt_reg  <= '0;
            optr_reg <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            nxt_reg  <= nxt_next;
            optr_reg <= optr_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        m_reg    <= m_next;
        hw_reg   <= hw_next;
        rptr_reg <= rptr_next;
        cnt_reg  <= cnt_next;
        z_reg    <= z_next;
        sum_reg  <= sum_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        dc_reg   <= dc_next;
        neg_reg  <= neg_next;
        mean_reg <= mean_next;
        pos_reg  <= pos_next;
        end_reg  <= end_next;
    end

    // sample ring
    always_ff @(posedge clk)
    begin
        if (q_pop)
            mem[e_ptr] <= e_sample;
        rd_reg <= mem[rptr_reg];
    end

    assign out_valid  = ov_reg;
    assign mean_value = mean_reg;
    assign position   = pos_reg;
    assign run_end    = end_reg;

endmodule

`default_nettype wire

@@ rtl/core/centered_moving_average_smoother_top.sv @@
// Top level of the centered moving average smoother.
//
// Input channel: sample / final_sample under in_valid, taken when in_stall
// is low. A series ends on an item with final_sample set, or at index
// 2^MAX_SERIES_LOG2-1. Output channel: mean_value (8 fraction bits,
// truncated toward zero), position and run_end under out_valid, taken
// when out_stall is low.
// The result for position i is produced once sample i+h has arrived; the
// last item of a series flushes all pending results.
// Each result goes through one span check, one ring read and one add per
// span term, a load step plus 29 quotient bits (at default sizes) from the
// restoring divider, then the output load. Each item adds a pop step, and
// one more span check unless it closes the series. Items are handled one
// at a time, two can wait in the input queue.
// cfg_we/cfg_wdata write window_length (reset 5).
// Reset empties the queue and output register and restarts the series.
// A stalled output holds its item; the back end waits with the next
// result ready and the input queue fills, then in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module centered_moving_average_smoother_top #(
    parameter int unsigned MAX_WINDOW      = 31,
    parameter int unsigned SAMPLE_BITS     = 16,
    parameter int unsigned MAX_SERIES_LOG2 = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [cma_pkg::WL_W-1:0]               cfg_wdata,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic [SAMPLE_BITS-1:0]                 sample,
    input  wire logic                                   final_sample,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic [SAMPLE_BITS+cma_pkg::FRAC_W-1:0]      mean_value,
    output logic [MAX_SERIES_LOG2-1:0]                  position,
    output logic                                        run_end
);

    localparam int unsigned PTR_W = $clog2(MAX_WINDOW);
    localparam int unsigned ENT_W = 1 + PTR_W + MAX_SERIES_LOG2 + SAMPLE_BITS;

    // window length register
    logic [cma_pkg::WL_W-1:0] wl_reg, wl_next;
    assign wl_next = cfg_we ? cfg_wdata : wl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wl_reg <= cma_pkg::WL_RESET;
        else
            wl_reg <= wl_next;
    end

    logic             push;
    logic [ENT_W-1:0] push_data;
    logic             q_full;
    logic             q_pop;
    logic             q_not_empty;
    logic [ENT_W-1:0] q_data;

    cma_front #(
        .MAX_WINDOW      (MAX_WINDOW),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .MAX_SERIES_LOG2 (MAX_SERIES_LOG2)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .final_sample (final_sample),
        .push         (push),
        .push_data    (push_data),
        .q_full       (q_full)
    );

    cma_queue #(
        .WIDTH (ENT_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_data)
    );

    cma_back #(
        .MAX_WINDOW      (MAX_WINDOW),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .MAX_SERIES_LOG2 (MAX_SERIES_LOG2)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .window_length (wl_reg),
        .q_not_empty   (q_not_empty),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .mean_value    (mean_value),
        .position      (position),
        .run_end       (run_end)
    );

    // an accepted item is in the queue on the next cycle
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> q_not_empty)
        else $error("accepted item missing from queue");

    // a stalled result stays put with its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(mean_value)
            && $stable(position) && $stable(run_end))
        else $error("stalled result changed");

endmodule

`default_nettype wire

@@ tb/cma_scoreboard.sv @@
// Scoreboard for the centered moving average smoother: predicts and checks results.
`timescale 1ns / 1ps

module cma_scoreboard (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [cma_pkg::WL_W-1:0]   cfg_wdata,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [15:0]                sample,
    input  logic                       final_sample,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [23:0]                mean_value,
    input  logic [15:0]                position,
    input  logic                       run_end,
    output int                         fail_count,
    output int                         means_waiting,
    output int                         means_checked
);

    localparam int RING = 31;
    localparam int HW_CAP = (RING - 1) / 2;

    typedef struct packed {
        logic [23:0] mean;
        logic [15:0] pos;
        logic        last;
    } mean_t;

    logic signed [15:0]      ring_q [RING];
    logic [15:0]             seen_cnt;
    int                      emit_idx;
    logic [cma_pkg::WL_W-1:0] win_len;
    mean_t                   mean_q [$];

    function automatic int half_win(logic [cma_pkg::WL_W-1:0] wl);
        int hw;
        hw = ((wl | 1) - 1) / 2;
        return (hw > HW_CAP) ? HW_CAP : hw;
    endfunction

    // Store one sample and queue every mean whose span is now complete.
    task automatic absorb_sample(logic signed [15:0] s, logic fin);
        int    m;
        int    hw;
        int    i;
        int    h;
        bit    last;
        longint acc;
        longint q;
        mean_t r;
        m = seen_cnt;
        hw = half_win(win_len);
        last = fin || (m == 16'hFFFF);
        ring_q[m % RING] = s;
        while (emit_idx <= m) begin
            i = emit_idx;
            if (!last && i + hw > m)
                break;
            h = hw;
            if (i < h)
                h = i;
            if (m - i < h)
                h = m - i;
            acc = 0;
            for (int j = i - h; j <= i + h; j++)
                acc += ring_q[j % RING];
            q = (acc * 256) / (2 * h + 1);
            r.mean = q[23:0];
            r.pos = i[15:0];
            r.last = last && (i == m);
            mean_q.insert(mean_q.size(), r);
            emit_idx = i + 1;
        end
        if (last) begin
            seen_cnt = 0;
            emit_idx = 0;
        end
        else
            seen_cnt = m + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        mean_t e;
        if (!rst_n) begin
            seen_cnt = 0;
            emit_idx = 0;
            win_len = cma_pkg::WL_RESET;
            mean_q.delete();
        end
        else begin
            if (cfg_we)
                win_len = cfg_wdata;
            if (in_valid && !in_stall)
                absorb_sample(sample, final_sample);
            if (out_valid && !out_stall) begin
                means_checked++;
                if (mean_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result mean=%h pos=%0d end=%b",
                             $time, mean_value, position, run_end);
                end
                else begin
                    e = mean_q.pop_front();
                    if (mean_value !== e.mean) begin
                        fail_count++;
                        $display("%0t: mean_value expected %h actual %h (pos %0d)",
                                 $time, e.mean, mean_value, e.pos);
                    end
                    if (position !== e.pos) begin
                        fail_count++;
                        $display("%0t: position expected %0d actual %0d",
                                 $time, e.pos, position);
                    end
                    if (run_end !== e.last) begin
                        fail_count++;
                        $display("%0t: run_end expected %b actual %b (pos %0d)",
                                 $time, e.last, run_end, e.pos);
                    end
                end
            end
        end
        means_waiting = mean_q.size();
    end

    initial
    begin
        fail_count = 0;
        means_waiting = 0;
        means_checked = 0;
    end

endmodule

@@ tb/centered_moving_average_smoother_top_tb.sv @@
// Testbench top for the centered moving average smoother: stimulus and verdict.
`timescale 1ns / 1ps

module centered_moving_average_smoother_top_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE = 300;      // covers the slowest result at window 31
    localparam int HOLD_LEN = 600;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [cma_pkg::WL_W-1:0]  cfg_wdata;
    logic                      in_valid;
    logic                      in_stall;
    logic [15:0]               sample;
    logic                      final_sample;
    logic                      out_valid;
    logic                      out_stall;
    logic [23:0]               mean_value;
    logic [15:0]               position;
    logic                      run_end;

    int fail_count;
    int means_waiting;
    int means_checked;
    int items_sent;
    int series_done;
    int cycles;
    bit calm_tx;   // no sender gaps while set
    bit calm_rx;   // no receiver stalls while set
    bit hold_req;  // asks the receiver for its long hold-off

    centered_moving_average_smoother_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .final_sample (final_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .mean_value   (mean_value),
        .position     (position),
        .run_end      (run_end)
    );

    cma_scoreboard sb (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample        (sample),
        .final_sample  (final_sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .mean_value    (mean_value),
        .position      (position),
        .run_end       (run_end),
        .fail_count    (fail_count),
        .means_waiting (means_waiting),
        .means_checked (means_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: a hung block ends the run here.
    initial
    begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d results pending",
                         cycles, means_waiting);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Receiver: random stall before each result, one long hold-off so the
    // block backs up and raises in_stall while the sender keeps offering.
    initial
    begin
        int k;
        bit held;
        out_stall = 1'b0;
        held = 1'b0;
        @(posedge rst_n);
        forever begin
            k = calm_rx ? 0 : $urandom_range(0, 18);
            if (hold_req && !held) begin
                k = HOLD_LEN;
                held = 1'b1;
            end
            if (k > 0) begin
                out_stall <= 1'b1;
                repeat (k) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
        end
    end

    // Offer one item; returns at the edge where it is taken.
    task automatic push_item(logic [15:0] s, logic fin);
        int gap;
        gap = calm_tx ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= s;
        final_sample <= fin;
        do @(posedge clk); while (in_stall);
        items_sent++;
        if (fin)
            series_done++;
    endtask

    // Window writes happen only with the block drained.
    task automatic set_window(logic [cma_pkg::WL_W-1:0] wl);
        in_valid <= 1'b0;
        @(posedge clk);
        while (means_waiting != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= wl;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly random samples, with full-scale values mixed in.
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    initial
    begin
        int len;
        int wl;
        logic [15:0] extremes [8];
        extremes = '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                     16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        sample = '0;
        final_sample = 1'b0;
        items_sent = 0;
        series_done = 0;
        calm_tx = 1'b0;
        calm_rx = 1'b0;
        hold_req = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero window rounds up to one: each mean is its own sample.
        set_window(5'd0);
        push_item(16'h8000, 1'b0);
        push_item(16'h7FFF, 1'b0);
        push_item(16'h0000, 1'b1);

        // Default-size window on one-, two- and four-sample series.
        set_window(5'd5);
        push_item(16'h7FFF, 1'b1);
        push_item(16'h8000, 1'b0);
        push_item(16'h8000, 1'b1);
        for (int i = 0; i < 4; i++)
            push_item(extremes[i], i == 3);

        // Widest window, series shorter than it: edges shrink on both sides.
        set_window(5'd31);
        for (int i = 0; i < 8; i++)
            push_item(extremes[i], i == 7);

        // Window shrinks mid-series: several pending means come out at once.
        set_window(5'd7);
        for (int i = 0; i < 6; i++)
            push_item(pick_sample(), 1'b0);
        set_window(5'd2);
        for (int i = 0; i < 3; i++)
            push_item(pick_sample(), i == 2);

        // Long receiver hold-off while the sender keeps offering a long series.
        set_window(5'd3);
        calm_tx = 1'b1;
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++)
            push_item(pick_sample(), i == 39);
        calm_tx = 1'b0;

        // Random series, mostly short, window changed now and then.
        while (items_sent < 310) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 3))
                    0: wl = 0;
                    1: wl = 31;
                    default: wl = $urandom_range(0, 31);
                endcase
                set_window(wl[4:0]);
            end
            calm_tx = ($urandom_range(0, 4) == 0);
            calm_rx = ($urandom_range(0, 4) == 0);
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 45)
                                               : $urandom_range(1, 12);
            // Now and then leave the series open so the next window
            // change lands in its middle.
            for (int i = 0; i < len; i++)
                push_item(pick_sample(),
                          (i == len - 1) && ($urandom_range(0, 5) != 0));
        end
        push_item(pick_sample(), 1'b1);
        in_valid <= 1'b0;

        while (means_waiting != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Sent %0d samples in %0d closed series; checked %0d means",
                 items_sent, series_done, means_checked);
        $display("Windows 0 to 31, mid-series changes, long output hold-off.");
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
